[rtl/core/region_map_protection_checker_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the region map protection checker
// ----------------------------------------------------------------------------
`ifndef REGION_MAP_PROTECTION_CHECKER_TOP_MACROS_SVH
`define REGION_MAP_PROTECTION_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define RMPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rmpc_pkg.sv]
// ----------------------------------------------------------------------------
// rmpc_pkg
// Types and codes shared by the region map protection checker.
// ----------------------------------------------------------------------------
package rmpc_pkg;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [2:0]  perms;
    logic        owned;
  } rmpc_entry_t;

  localparam int ENTRY_W = $bits(rmpc_entry_t);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_LIMIT     = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNMAPPED  = 3'd4,
    ST_DENIED    = 3'd5,
    ST_LOADER    = 3'd6,
    ST_UNDERFLOW = 3'd7
  } rmpc_status_t;

  typedef enum logic [2:0] {
    MODE_MAP     = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_READ    = 3'd2,
    MODE_WRITE   = 3'd3,
    MODE_LOADER  = 3'd4,
    MODE_QUERY   = 3'd5,
    MODE_STAT    = 3'd6,
    MODE_UNUSED  = 3'd7
  } rmpc_mode_t;

  typedef enum logic [3:0] {
    SEL_LIVE_COUNT   = 4'd0,
    SEL_LIVE_BYTES   = 4'd1,
    SEL_CUM_BYTES    = 4'd2,
    SEL_PEAK_BYTES   = 4'd3,
    SEL_PEAK_COUNT   = 4'd4,
    SEL_HIGH_WATER   = 4'd5,
    SEL_OWN_CREATED  = 4'd6,
    SEL_OWN_RECLAIM  = 4'd7,
    SEL_OWN_COUNT    = 4'd8,
    SEL_OWN_BYTES    = 4'd9,
    SEL_OWN_PEAK     = 4'd10,
    SEL_OWN_CUM      = 4'd11
  } rmpc_sel_t;

  localparam logic [1:0] CFG_MAX_REGION_SIZE    = 2'd0;
  localparam logic [1:0] CFG_MAX_TOTAL_SIZE     = 2'd1;
  localparam logic [1:0] CFG_MAX_REGION_ENTRIES = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_RD, S_EV, S_POST1, S_POST2, S_SHRD, S_SHWR, S_WRPOS, S_DONE
  } rmpc_state_t;

endpackage

[rtl/core/rmpc_ram.sv]
// ----------------------------------------------------------------------------
// rmpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/region_map_protection_checker_top.sv]
// ----------------------------------------------------------------------------
// region_map_protection_checker_top
// Sorted guest region table with map, release, access checks and accounting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request transaction (mode, address, length,
//   perm_bits, owned, stat_select), taken when in_valid is high and in_stall
//   low. Output channel out_*: one result transaction per request, taken
//   when out_valid is high and out_stall low. cfg_we writes a limit register.
// Table: the table lives in a RAM and is searched one entry at a time,
//   through a read state and an evaluate state, by a small sequencer with
//   a shared 64-bit adder/subtractor. Stat reads and early rejects finish
//   without a search. The search stops at the first entry at or above the
//   address; on a map or release the entries above the slot then move one
//   at a time through a read state and a write state.
// Throughput: one request at a time; in_stall is high while one is in work.
// Reset: clears counters and the table fill count; limits go to all ones
//   and 64 entries. Table contents need no clearing.
// Stall: a finished result waits in the sequencer until the output register
//   frees; out_* hold steady while out_stall is high.
// ----------------------------------------------------------------------------
`include "region_map_protection_checker_top_macros.svh"

module region_map_protection_checker_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_address,
  input  logic [63:0] in_length,
  input  logic [3:0]  in_perm_bits,
  input  logic        in_owned,
  input  logic [3:0]  in_stat_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_region_index,
  output logic [63:0] out_region_offset,
  output logic [2:0]  out_region_perms,
  output logic        out_executable,
  output logic [63:0] out_stat_value
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
  localparam logic [63:0] ALL_ONES = '1;

  // configuration
  logic [63:0] max_rs_r, max_ts_r;
  logic [6:0]  max_re_r;

  // accounting
  logic [CW-1:0] live_count_r, live_count_nxt, peak_count_r, peak_count_nxt;
  logic [CW-1:0] olc_r, olc_nxt;
  logic [63:0] live_bytes_r, live_bytes_nxt, cum_r, cum_nxt, peak_bytes_r, peak_bytes_nxt;
  logic [63:0] hw_r, hw_nxt, created_r, created_nxt, reclaimed_r, reclaimed_nxt;
  logic [63:0] olb_r, olb_nxt, opeak_r, opeak_nxt, ocum_r, ocum_nxt;

  // sequencer
  rmpc_pkg::rmpc_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [CW-1:0] idx_r, idx_nxt, pos_r, pos_nxt, sel_idx_r, sel_idx_nxt;
  logic [2:0]  mode_r;
  logic [63:0] addr_r, len_r;
  logic [3:0]  perm_r, ssel_r;
  logic        own_r;
  logic [63:0] end_r, end_nxt, s_total_r, s_total_nxt, s_cum_r, s_cum_nxt;
  logic [63:0] s_olb_r, s_olb_nxt, s_ocum_r, s_ocum_nxt, off_r, off_nxt;
  rmpc_pkg::rmpc_entry_t prev_r, prev_nxt, next_r, next_nxt, sel_r, sel_nxt;
  logic        prev_v_r, prev_v_nxt, next_v_r, next_v_nxt, hit_r, hit_nxt;

  // result
  logic [2:0]  rs_status_r, rs_status_nxt, rs_perms_r, rs_perms_nxt;
  logic [CW-1:0] rs_index_r, rs_index_nxt;
  logic [63:0] rs_offset_r, rs_offset_nxt, rs_stat_r, rs_stat_nxt;
  logic        rs_exec_r, rs_exec_nxt;

  logic        out_valid_r;
  logic [2:0]  out_status_r, out_perms_r;
  logic [5:0]  out_index_r;
  logic [63:0] out_offset_r, out_stat_r;
  logic        out_exec_r;

  // shared adder / subtractor
  logic [63:0] alu_a, alu_b;
  logic        alu_sub;
  logic [64:0] alu_sum;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rmpc_pkg::rmpc_entry_t ram_wdata, ram_rdata;
  logic [rmpc_pkg::ENTRY_W-1:0] ram_rbits;

  logic [LW-1:0] limit_w;
  logic          accept, out_free, is_map;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != rmpc_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign is_map   = (mode_r == rmpc_pkg::MODE_MAP);
  assign limit_w  = (LW'(max_re_r) < DEPTH_L) ? LW'(max_re_r) : DEPTH_L;
  assign alu_sum  = alu_sub ? ({1'b0, alu_a} + {1'b0, ~alu_b} + 65'd1)
                            : ({1'b0, alu_a} + {1'b0, alu_b});
  assign ram_rdata = rmpc_pkg::rmpc_entry_t'(ram_rbits);

  rmpc_ram #(
    .WIDTH (rmpc_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  always_comb begin
    state_nxt = state_r; step_nxt = step_r; idx_nxt = idx_r; pos_nxt = pos_r;
    sel_idx_nxt = sel_idx_r;
    end_nxt = end_r; s_total_nxt = s_total_r; s_cum_nxt = s_cum_r;
    s_olb_nxt = s_olb_r; s_ocum_nxt = s_ocum_r; off_nxt = off_r;
    prev_nxt = prev_r; next_nxt = next_r; sel_nxt = sel_r;
    prev_v_nxt = prev_v_r; next_v_nxt = next_v_r; hit_nxt = hit_r;
    rs_status_nxt = rs_status_r; rs_perms_nxt = rs_perms_r; rs_index_nxt = rs_index_r;
    rs_offset_nxt = rs_offset_r; rs_stat_nxt = rs_stat_r; rs_exec_nxt = rs_exec_r;
    live_count_nxt = live_count_r; peak_count_nxt = peak_count_r; olc_nxt = olc_r;
    live_bytes_nxt = live_bytes_r; cum_nxt = cum_r; peak_bytes_nxt = peak_bytes_r;
    hw_nxt = hw_r; created_nxt = created_r; reclaimed_nxt = reclaimed_r;
    olb_nxt = olb_r; opeak_nxt = opeak_r; ocum_nxt = ocum_r;
    alu_a = addr_r; alu_b = len_r; alu_sub = 1'b0;
    ram_we = 1'b0; ram_waddr = idx_r[AW-1:0]; ram_raddr = idx_r[AW-1:0];
    ram_wdata = '{base: addr_r, size: len_r, perms: perm_r[2:0], owned: own_r};

    case (state_r)
      rmpc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = rmpc_pkg::S_PRE; step_nxt = '0;
          rs_status_nxt = rmpc_pkg::ST_OK; rs_perms_nxt = '0; rs_index_nxt = '0;
          rs_offset_nxt = '0; rs_stat_nxt = '0; rs_exec_nxt = 1'b0;
        end
      end
      rmpc_pkg::S_PRE: begin
        case (mode_r)
          rmpc_pkg::MODE_MAP: begin
            case (step_r)
              3'd0: begin
                if (perm_r[3]) begin
                  rs_status_nxt = rmpc_pkg::ST_INVALID; state_nxt = rmpc_pkg::S_DONE;
                end else if (len_r == '0) begin
                  state_nxt = rmpc_pkg::S_DONE;
                end else if (len_r > max_rs_r) begin
                  rs_status_nxt = rmpc_pkg::ST_LIMIT; state_nxt = rmpc_pkg::S_DONE;
                end else begin
                  step_nxt = 3'd1;
                end
              end
              3'd1: begin
                end_nxt = alu_sum[63:0];
                if (alu_sum[64]) begin
                  rs_status_nxt = rmpc_pkg::ST_OVERFLOW; state_nxt = rmpc_pkg::S_DONE;
                end else begin
                  step_nxt = 3'd2;
                end
              end
              3'd2: begin
                alu_a = live_bytes_r;
                s_total_nxt = alu_sum[63:0];
                if (alu_sum[64]) begin
                  rs_status_nxt = rmpc_pkg::ST_OVERFLOW; state_nxt = rmpc_pkg::S_DONE;
                end else if (alu_sum[63:0] > max_ts_r ||
                             LW'(live_count_r) >= limit_w) begin
                  rs_status_nxt = rmpc_pkg::ST_LIMIT; state_nxt = rmpc_pkg::S_DONE;
                end else begin
                  step_nxt = 3'd3;
                end
              end
              3'd3: begin
                alu_a = cum_r;
                s_cum_nxt = alu_sum[63:0];
                if (alu_sum[64]) begin
                  rs_status_nxt = rmpc_pkg::ST_OVERFLOW; state_nxt = rmpc_pkg::S_DONE;
                end else if (own_r) begin
                  step_nxt = 3'd4;
                end else begin
                  step_nxt = 3'd6;
                end
              end
              3'd4: begin
                alu_a = olb_r;
                s_olb_nxt = alu_sum[63:0];
                if (created_r == ALL_ONES || alu_sum[64]) begin
                  rs_status_nxt = rmpc_pkg::ST_OVERFLOW; state_nxt = rmpc_pkg::S_DONE;
                end else begin
                  step_nxt = 3'd5;
                end
              end
              3'd5: begin
                alu_a = ocum_r;
                s_ocum_nxt = alu_sum[63:0];
                if (alu_sum[64]) begin
                  rs_status_nxt = rmpc_pkg::ST_OVERFLOW; state_nxt = rmpc_pkg::S_DONE;
                end else begin
                  step_nxt = 3'd6;
                end
              end
              default: step_nxt = 3'd7;
            endcase
          end
          rmpc_pkg::MODE_RELEASE: step_nxt = 3'd7;
          rmpc_pkg::MODE_READ, rmpc_pkg::MODE_WRITE,
          rmpc_pkg::MODE_LOADER, rmpc_pkg::MODE_QUERY: begin
            end_nxt = alu_sum[63:0];
            if (len_r == '0 && mode_r == rmpc_pkg::MODE_LOADER) begin
              state_nxt = rmpc_pkg::S_DONE;
            end else if (len_r == '0 && mode_r == rmpc_pkg::MODE_QUERY) begin
              rs_status_nxt = rmpc_pkg::ST_INVALID; state_nxt = rmpc_pkg::S_DONE;
            end else if (alu_sum[64]) begin
              rs_status_nxt = rmpc_pkg::ST_OVERFLOW; state_nxt = rmpc_pkg::S_DONE;
            end else begin
              step_nxt = 3'd7;
            end
          end
          rmpc_pkg::MODE_STAT: begin
            state_nxt = rmpc_pkg::S_DONE;
            case (ssel_r)
              rmpc_pkg::SEL_LIVE_COUNT:  rs_stat_nxt = 64'(live_count_r);
              rmpc_pkg::SEL_LIVE_BYTES:  rs_stat_nxt = live_bytes_r;
              rmpc_pkg::SEL_CUM_BYTES:   rs_stat_nxt = cum_r;
              rmpc_pkg::SEL_PEAK_BYTES:  rs_stat_nxt = peak_bytes_r;
              rmpc_pkg::SEL_PEAK_COUNT:  rs_stat_nxt = 64'(peak_count_r);
              rmpc_pkg::SEL_HIGH_WATER:  rs_stat_nxt = hw_r;
              rmpc_pkg::SEL_OWN_CREATED: rs_stat_nxt = created_r;
              rmpc_pkg::SEL_OWN_RECLAIM: rs_stat_nxt = reclaimed_r;
              rmpc_pkg::SEL_OWN_COUNT:   rs_stat_nxt = 64'(olc_r);
              rmpc_pkg::SEL_OWN_BYTES:   rs_stat_nxt = olb_r;
              rmpc_pkg::SEL_OWN_PEAK:    rs_stat_nxt = opeak_r;
              rmpc_pkg::SEL_OWN_CUM:     rs_stat_nxt = ocum_r;
              default:                   rs_status_nxt = rmpc_pkg::ST_INVALID;
            endcase
          end
          default: begin
            rs_status_nxt = rmpc_pkg::ST_INVALID; state_nxt = rmpc_pkg::S_DONE;
          end
        endcase
        // start of the table search
        if (state_nxt == rmpc_pkg::S_PRE && step_nxt == 3'd7) begin
          idx_nxt = '0; pos_nxt = '0; prev_v_nxt = 1'b0; next_v_nxt = 1'b0;
          state_nxt = (live_count_r == '0) ? rmpc_pkg::S_POST1 : rmpc_pkg::S_RD;
        end else if (state_nxt == rmpc_pkg::S_PRE && step_nxt == 3'd6) begin
          step_nxt = 3'd7;
          idx_nxt = '0; pos_nxt = '0; prev_v_nxt = 1'b0; next_v_nxt = 1'b0;
          state_nxt = (live_count_r == '0) ? rmpc_pkg::S_POST1 : rmpc_pkg::S_RD;
        end
      end
      rmpc_pkg::S_RD: state_nxt = rmpc_pkg::S_EV;
      rmpc_pkg::S_EV: begin
        // first entry at or above the key ends the search
        if (ram_rdata.base < addr_r) begin
          prev_nxt = ram_rdata; prev_v_nxt = 1'b1;
          if (CW'(idx_r + 1'b1) == live_count_r) begin
            pos_nxt = live_count_r; state_nxt = rmpc_pkg::S_POST1;
          end else begin
            idx_nxt = CW'(idx_r + 1'b1); state_nxt = rmpc_pkg::S_RD;
          end
        end else begin
          next_nxt = ram_rdata; next_v_nxt = 1'b1; pos_nxt = idx_r;
          state_nxt = rmpc_pkg::S_POST1;
        end
      end
      rmpc_pkg::S_POST1: begin
        state_nxt = rmpc_pkg::S_POST2;
        if (is_map) begin
          if (next_v_r && next_r.base < end_r) begin
            rs_status_nxt = rmpc_pkg::ST_INVALID; state_nxt = rmpc_pkg::S_DONE;
          end
        end else if (mode_r == rmpc_pkg::MODE_RELEASE) begin
          alu_a = live_bytes_r; alu_sub = 1'b1;
          if (!(next_v_r && next_r.base == addr_r && next_r.size == len_r &&
                next_r.owned)) begin
            rs_status_nxt = rmpc_pkg::ST_INVALID; state_nxt = rmpc_pkg::S_DONE;
          end else if (live_bytes_r < len_r || olb_r < len_r || olc_r == '0 ||
                       reclaimed_r == ALL_ONES || reclaimed_r >= created_r) begin
            rs_status_nxt = rmpc_pkg::ST_UNDERFLOW; state_nxt = rmpc_pkg::S_DONE;
          end else begin
            live_count_nxt = CW'(live_count_r - 1'b1);
            live_bytes_nxt = alu_sum[63:0];
            olb_nxt        = olb_r - len_r;
            olc_nxt        = CW'(olc_r - 1'b1);
            reclaimed_nxt  = reclaimed_r + 64'd1;
            rs_index_nxt   = pos_r;
            idx_nxt        = pos_r;
            // entries above the freed slot move down by one
            state_nxt = (pos_r < CW'(live_count_r - 1'b1)) ? rmpc_pkg::S_SHRD
                                                           : rmpc_pkg::S_DONE;
          end
        end else begin
          alu_b = prev_r.base; alu_sub = 1'b1;
          if (next_v_r && next_r.base == addr_r) begin
            sel_nxt = next_r; sel_idx_nxt = pos_r; off_nxt = '0; hit_nxt = 1'b1;
          end else if (prev_v_r) begin
            sel_nxt = prev_r; sel_idx_nxt = CW'(pos_r - 1'b1);
            off_nxt = alu_sum[63:0]; hit_nxt = (alu_sum[63:0] < prev_r.size);
          end else begin
            hit_nxt = 1'b0;
          end
        end
      end
      rmpc_pkg::S_POST2: begin
        if (is_map) begin
          alu_a = prev_r.base; alu_b = prev_r.size;
          if (prev_v_r && alu_sum[63:0] > addr_r) begin
            rs_status_nxt = rmpc_pkg::ST_INVALID; state_nxt = rmpc_pkg::S_DONE;
          end else begin
            live_count_nxt = CW'(live_count_r + 1'b1);
            live_bytes_nxt = s_total_r;
            cum_nxt        = s_cum_r;
            if (s_total_r > peak_bytes_r) peak_bytes_nxt = s_total_r;
            if (CW'(live_count_r + 1'b1) > peak_count_r) begin
              peak_count_nxt = CW'(live_count_r + 1'b1);
            end
            if (end_r > hw_r) hw_nxt = end_r;
            if (own_r) begin
              created_nxt = created_r + 64'd1;
              olc_nxt     = CW'(olc_r + 1'b1);
              olb_nxt     = s_olb_r;
              ocum_nxt    = s_ocum_r;
              if (s_olb_r > opeak_r) opeak_nxt = s_olb_r;
            end
            rs_index_nxt = pos_r;
            idx_nxt      = live_count_r;
            state_nxt = (live_count_r > pos_r) ? rmpc_pkg::S_SHRD : rmpc_pkg::S_WRPOS;
          end
        end else begin
          alu_a = sel_r.base; alu_b = sel_r.size;
          state_nxt = rmpc_pkg::S_DONE;
          if (!hit_r || end_r > alu_sum[63:0]) begin
            rs_status_nxt = (mode_r == rmpc_pkg::MODE_LOADER) ? rmpc_pkg::ST_LOADER
                                                              : rmpc_pkg::ST_UNMAPPED;
          end else if ((mode_r == rmpc_pkg::MODE_READ && !sel_r.perms[0]) ||
                       (mode_r == rmpc_pkg::MODE_WRITE && !sel_r.perms[1])) begin
            rs_status_nxt = rmpc_pkg::ST_DENIED;
          end else begin
            rs_index_nxt  = sel_idx_r;
            rs_offset_nxt = off_r;
            rs_perms_nxt  = sel_r.perms;
            rs_exec_nxt   = (mode_r == rmpc_pkg::MODE_QUERY) && sel_r.perms[2];
          end
        end
      end
      rmpc_pkg::S_SHRD: begin
        ram_raddr = is_map ? AW'(idx_r - 1'b1) : AW'(idx_r + 1'b1);
        state_nxt = rmpc_pkg::S_SHWR;
      end
      rmpc_pkg::S_SHWR: begin
        ram_we = 1'b1; ram_waddr = idx_r[AW-1:0]; ram_wdata = ram_rdata;
        if (is_map) begin
          idx_nxt   = CW'(idx_r - 1'b1);
          state_nxt = (CW'(idx_r - 1'b1) > pos_r) ? rmpc_pkg::S_SHRD : rmpc_pkg::S_WRPOS;
        end else begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = (CW'(idx_r + 1'b1) < live_count_r) ? rmpc_pkg::S_SHRD
                                                         : rmpc_pkg::S_DONE;
        end
      end
      rmpc_pkg::S_WRPOS: begin
        ram_we = 1'b1; ram_waddr = pos_r[AW-1:0];
        state_nxt = rmpc_pkg::S_DONE;
      end
      rmpc_pkg::S_DONE: begin
        if (out_free) state_nxt = rmpc_pkg::S_IDLE;
      end
      default: state_nxt = rmpc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmpc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      max_rs_r <= ALL_ONES; max_ts_r <= ALL_ONES; max_re_r <= 7'd64;
      live_count_r <= '0; peak_count_r <= '0; olc_r <= '0;
      live_bytes_r <= '0; cum_r <= '0; peak_bytes_r <= '0; hw_r <= '0;
      created_r <= '0; reclaimed_r <= '0; olb_r <= '0; opeak_r <= '0; ocum_r <= '0;
    end else begin
      state_r <= state_nxt;
      live_count_r <= live_count_nxt; peak_count_r <= peak_count_nxt; olc_r <= olc_nxt;
      live_bytes_r <= live_bytes_nxt; cum_r <= cum_nxt; peak_bytes_r <= peak_bytes_nxt;
      hw_r <= hw_nxt; created_r <= created_nxt; reclaimed_r <= reclaimed_nxt;
      olb_r <= olb_nxt; opeak_r <= opeak_nxt; ocum_r <= ocum_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rmpc_pkg::CFG_MAX_REGION_SIZE:    max_rs_r <= cfg_wdata;
          rmpc_pkg::CFG_MAX_TOTAL_SIZE:     max_ts_r <= cfg_wdata;
          rmpc_pkg::CFG_MAX_REGION_ENTRIES: max_re_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (state_r == rmpc_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt; sel_idx_r <= sel_idx_nxt;
    end_r <= end_nxt; s_total_r <= s_total_nxt; s_cum_r <= s_cum_nxt;
    s_olb_r <= s_olb_nxt; s_ocum_r <= s_ocum_nxt; off_r <= off_nxt;
    prev_r <= prev_nxt; next_r <= next_nxt; sel_r <= sel_nxt;
    prev_v_r <= prev_v_nxt; next_v_r <= next_v_nxt; hit_r <= hit_nxt;
    rs_status_r <= rs_status_nxt; rs_perms_r <= rs_perms_nxt; rs_index_r <= rs_index_nxt;
    rs_offset_r <= rs_offset_nxt; rs_stat_r <= rs_stat_nxt; rs_exec_r <= rs_exec_nxt;
    if (accept) begin
      mode_r <= in_mode; addr_r <= in_address; len_r <= in_length;
      perm_r <= in_perm_bits; own_r <= in_owned; ssel_r <= in_stat_select;
    end
    if (state_r == rmpc_pkg::S_DONE && out_free) begin
      out_status_r <= rs_status_r;
      out_index_r  <= 6'(rs_index_r);
      out_offset_r <= rs_offset_r;
      out_perms_r  <= rs_perms_r;
      out_exec_r   <= rs_exec_r;
      out_stat_r   <= rs_stat_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_region_index  = out_index_r;
  assign out_region_offset = out_offset_r;
  assign out_region_perms  = out_perms_r;
  assign out_executable    = out_exec_r;
  assign out_stat_value    = out_stat_r;

  `RMPC_ASSERT_NOW(a_live_bound, clk, rst_n, 1'b1, live_count_r <= CW'(TABLE_DEPTH), "live count above table depth")
  `RMPC_ASSERT_NOW(a_owned_bound, clk, rst_n, 1'b1, olc_r <= live_count_r, "owned count above live count")
  `RMPC_ASSERT_NOW(a_reclaim_bound, clk, rst_n, 1'b1, reclaimed_r <= created_r, "more reclaimed than created")
  `RMPC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, state_r != rmpc_pkg::S_IDLE, "idle right after accept")

endmodule

[test/region_map_protection_checker_top_tb.sv]
// ----------------------------------------------------------------------------
// region_map_protection_checker_top_tb
// Drives map, release, access check, query and stat transactions into the
// region table under several limit settings. A scoreboard keeps its own copy
// of the table and counters and checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module region_map_protection_checker_top_tb;

  localparam int DEPTH = 64;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [63:0] offset;
    logic [2:0]  perms;
    logic        exec;
    logic [63:0] stat;
  } region_result_t;

  class region_scoreboard;
    logic [63:0] rbase[DEPTH];
    logic [63:0] rsize[DEPTH];
    logic [2:0]  rperm[DEPTH];
    logic        rown[DEPTH];
    int          nlive;
    logic [63:0] live_bytes, cum_bytes, peak_bytes, peak_cnt, high_water;
    logic [63:0] own_created, own_reclaimed, own_cnt, own_bytes, own_peak, own_cum;
    logic [63:0] lim_size, lim_total;
    logic [6:0]  lim_entries;
    region_result_t expected_q[$];
    int errors, nchecked, nmapped, nreleased, naccess_ok;

    function new();
      nlive = 0;
      {live_bytes, cum_bytes, peak_bytes, peak_cnt, high_water} = '0;
      {own_created, own_reclaimed, own_cnt, own_bytes, own_peak, own_cum} = '0;
      lim_size = ALL_ONES;
      lim_total = ALL_ONES;
      lim_entries = 7'd64;
      errors = 0;
      nchecked = 0;
      nmapped = 0;
      nreleased = 0;
      naccess_ok = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [63:0] val);
      case (idx)
        rmpc_pkg::CFG_MAX_REGION_SIZE:    lim_size = val;
        rmpc_pkg::CFG_MAX_TOTAL_SIZE:     lim_total = val;
        rmpc_pkg::CFG_MAX_REGION_ENTRIES: lim_entries = val[6:0];
        default: ;
      endcase
    endfunction

    function int lower_pos(logic [63:0] v);
      int n;
      n = 0;
      for (int i = 0; i < nlive; i++) if (rbase[i] < v) n++;
      return n;
    endfunction

    function int locate_entry(logic [63:0] a);
      int p;
      p = lower_pos(a);
      if (p < nlive && rbase[p] == a) return p;
      if (p == 0) return -1;
      p--;
      if (a - rbase[p] < rsize[p]) return p;
      return -1;
    endfunction

    function logic [2:0] map_region(logic [63:0] b, logic [63:0] sz, logic [3:0] pb,
                                     logic own, output logic [5:0] idx);
      logic [64:0] stop, tot;
      int lim, p;
      idx = '0;
      lim = (lim_entries < DEPTH) ? lim_entries : DEPTH;
      stop = {1'b0, b} + sz;
      tot = {1'b0, live_bytes} + sz;
      if (pb[3]) return rmpc_pkg::ST_INVALID;
      if (sz == 0) return rmpc_pkg::ST_OK;
      if (sz > lim_size) return rmpc_pkg::ST_LIMIT;
      if (stop[64] || tot[64]) return rmpc_pkg::ST_OVERFLOW;
      if (tot[63:0] > lim_total) return rmpc_pkg::ST_LIMIT;
      if (nlive + 1 > lim) return rmpc_pkg::ST_LIMIT;
      if (cum_bytes + sz < cum_bytes) return rmpc_pkg::ST_OVERFLOW;
      if (own && (own_created == ALL_ONES || own_bytes + sz < own_bytes ||
                  own_cum + sz < own_cum))
        return rmpc_pkg::ST_OVERFLOW;
      p = lower_pos(b);
      if (p < nlive && rbase[p] < stop[63:0]) return rmpc_pkg::ST_INVALID;
      if (p > 0 && rbase[p-1] + rsize[p-1] > b) return rmpc_pkg::ST_INVALID;
      for (int i = nlive; i > p; i--) begin
        rbase[i] = rbase[i-1];
        rsize[i] = rsize[i-1];
        rperm[i] = rperm[i-1];
        rown[i] = rown[i-1];
      end
      rbase[p] = b;
      rsize[p] = sz;
      rperm[p] = pb[2:0];
      rown[p] = own;
      nlive++;
      live_bytes = tot[63:0];
      cum_bytes += sz;
      if (live_bytes > peak_bytes) peak_bytes = live_bytes;
      if (nlive > peak_cnt) peak_cnt = nlive;
      if (stop[63:0] > high_water) high_water = stop[63:0];
      if (own) begin
        own_created++;
        own_cnt++;
        own_bytes += sz;
        if (own_bytes > own_peak) own_peak = own_bytes;
        own_cum += sz;
      end
      idx = p[5:0];
      nmapped++;
      return rmpc_pkg::ST_OK;
    endfunction

    function logic [2:0] release_region(logic [63:0] b, logic [63:0] sz,
                                        output logic [5:0] idx);
      int p;
      idx = '0;
      p = lower_pos(b);
      if (p >= nlive || rbase[p] != b || rsize[p] != sz || !rown[p])
        return rmpc_pkg::ST_INVALID;
      if (live_bytes < sz || own_bytes < sz || own_cnt == 0 ||
          own_reclaimed == ALL_ONES || own_reclaimed + 1 > own_created)
        return rmpc_pkg::ST_UNDERFLOW;
      for (int i = p; i + 1 < nlive; i++) begin
        rbase[i] = rbase[i+1];
        rsize[i] = rsize[i+1];
        rperm[i] = rperm[i+1];
        rown[i] = rown[i+1];
      end
      nlive--;
      live_bytes -= sz;
      own_bytes -= sz;
      own_cnt--;
      own_reclaimed++;
      idx = p[5:0];
      nreleased++;
      return rmpc_pkg::ST_OK;
    endfunction

    // note an accepted request: update the table and queue its result
    function void note_request(logic [2:0] md, logic [63:0] a, logic [63:0] len,
                               logic [3:0] pb, logic own, logic [3:0] sel);
      region_result_t r;
      logic [64:0] sum;
      int hit;
      r = '0;
      r.status = rmpc_pkg::ST_OK;
      sum = {1'b0, a} + len;
      case (md)
        rmpc_pkg::MODE_MAP:     r.status = map_region(a, len, pb, own, r.index);
        rmpc_pkg::MODE_RELEASE: r.status = release_region(a, len, r.index);
        rmpc_pkg::MODE_READ, rmpc_pkg::MODE_WRITE,
        rmpc_pkg::MODE_LOADER, rmpc_pkg::MODE_QUERY: begin
          if ((md == rmpc_pkg::MODE_LOADER || md == rmpc_pkg::MODE_QUERY) && len == 0) begin
            r.status = (md == rmpc_pkg::MODE_LOADER) ? rmpc_pkg::ST_OK : rmpc_pkg::ST_INVALID;
          end else if (sum[64]) begin
            r.status = rmpc_pkg::ST_OVERFLOW;
          end else begin
            hit = locate_entry(a);
            if (hit < 0 || sum[63:0] > rbase[hit] + rsize[hit]) begin
              r.status = (md == rmpc_pkg::MODE_LOADER) ? rmpc_pkg::ST_LOADER
                                                       : rmpc_pkg::ST_UNMAPPED;
            end else if (md == rmpc_pkg::MODE_READ && !rperm[hit][0]) begin
              r.status = rmpc_pkg::ST_DENIED;
            end else if (md == rmpc_pkg::MODE_WRITE && !rperm[hit][1]) begin
              r.status = rmpc_pkg::ST_DENIED;
            end else begin
              r.index = hit[5:0];
              r.offset = a - rbase[hit];
              r.perms = rperm[hit];
              if (md == rmpc_pkg::MODE_QUERY) r.exec = rperm[hit][2];
              naccess_ok++;
            end
          end
        end
        rmpc_pkg::MODE_STAT: begin
          case (sel)
            rmpc_pkg::SEL_LIVE_COUNT:  r.stat = nlive;
            rmpc_pkg::SEL_LIVE_BYTES:  r.stat = live_bytes;
            rmpc_pkg::SEL_CUM_BYTES:   r.stat = cum_bytes;
            rmpc_pkg::SEL_PEAK_BYTES:  r.stat = peak_bytes;
            rmpc_pkg::SEL_PEAK_COUNT:  r.stat = peak_cnt;
            rmpc_pkg::SEL_HIGH_WATER:  r.stat = high_water;
            rmpc_pkg::SEL_OWN_CREATED: r.stat = own_created;
            rmpc_pkg::SEL_OWN_RECLAIM: r.stat = own_reclaimed;
            rmpc_pkg::SEL_OWN_COUNT:   r.stat = own_cnt;
            rmpc_pkg::SEL_OWN_BYTES:   r.stat = own_bytes;
            rmpc_pkg::SEL_OWN_PEAK:    r.stat = own_peak;
            rmpc_pkg::SEL_OWN_CUM:     r.stat = own_cum;
            default:                   r.status = rmpc_pkg::ST_INVALID;
          endcase
        end
        default: r.status = rmpc_pkg::ST_INVALID;
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(region_result_t got);
      region_result_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      nchecked++;
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.index !== e.index) begin
        $error("region_index: expected %0d, got %0d", e.index, got.index);
        errors++;
      end
      if (got.offset !== e.offset) begin
        $error("region_offset: expected %h, got %h", e.offset, got.offset);
        errors++;
      end
      if (got.perms !== e.perms) begin
        $error("region_perms: expected %0d, got %0d", e.perms, got.perms);
        errors++;
      end
      if (got.exec !== e.exec) begin
        $error("executable: expected %0d, got %0d", e.exec, got.exec);
        errors++;
      end
      if (got.stat !== e.stat) begin
        $error("stat_value: expected %h, got %h", e.stat, got.stat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [63:0] in_address = '0;
  logic [63:0] in_length = '0;
  logic [3:0]  in_perm_bits = '0;
  logic        in_owned = 1'b0;
  logic [3:0]  in_stat_select = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [5:0]  out_region_index;
  logic [63:0] out_region_offset;
  logic [2:0]  out_region_perms;
  logic        out_executable;
  logic [63:0] out_stat_value;

  region_scoreboard region_sb = new();
  longint unsigned cycles = 0;
  int          nsent = 0;
  logic [63:0] win_base = 64'h0000_0000_0010_0000;

  region_map_protection_checker_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("region_map_protection_checker_top verification failed");
      $finish;
    end
  end

  // receiver stall pattern: free-flowing, random, or long stalls, in segments
  int stall_kind = 0;
  int stall_left = 0;
  int stall_hold = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      default: begin
        if (stall_hold == 0) stall_hold = $urandom_range(1, 20);
        stall_hold--;
        out_stall <= (stall_hold > 3);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      region_sb.check_result({out_status, out_region_index, out_region_offset,
                              out_region_perms, out_executable, out_stat_value});
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(logic [2:0] md, logic [63:0] a, logic [63:0] len,
                          logic [3:0] pb, logic own, logic [3:0] sel);
    in_valid <= 1'b1;
    in_mode <= md;
    in_address <= a;
    in_length <= len;
    in_perm_bits <= pb;
    in_owned <= own;
    in_stat_select <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    region_sb.note_request(md, a, len, pb, own, sel);
    nsent++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] win_addr();
    return win_base + $urandom_range(0, 63) * 512 + $urandom_range(0, 3) * 64;
  endfunction

  task automatic send_random();
    logic [2:0]  md;
    logic [63:0] a, len;
    logic [3:0]  pb, sel;
    logic        own;
    int          pick, i;
    pick = $urandom_range(0, 99);
    a = win_addr();
    len = $urandom_range(1, 400);
    pb = $urandom_range(0, 7);
    own = ($urandom_range(0, 99) < 85);
    sel = $urandom_range(0, 15);
    if (pick < 22) md = rmpc_pkg::MODE_MAP;
    else if (pick < 34) md = rmpc_pkg::MODE_RELEASE;
    else if (pick < 52) md = rmpc_pkg::MODE_READ;
    else if (pick < 64) md = rmpc_pkg::MODE_WRITE;
    else if (pick < 74) md = rmpc_pkg::MODE_LOADER;
    else if (pick < 84) md = rmpc_pkg::MODE_QUERY;
    else if (pick < 96) md = rmpc_pkg::MODE_STAT;
    else md = rmpc_pkg::MODE_UNUSED;
    case (md)
      rmpc_pkg::MODE_MAP: begin
        if ($urandom_range(0, 99) < 15) a = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 5) len = '0;
        else if (pick < 15) len = rand64() >> $urandom_range(0, 63);
        if ($urandom_range(0, 99) < 7) pb = $urandom_range(8, 15);
      end
      rmpc_pkg::MODE_RELEASE: begin
        if (region_sb.nlive > 0 && $urandom_range(0, 99) < 75) begin
          i = $urandom_range(0, region_sb.nlive - 1);
          a = region_sb.rbase[i];
          len = region_sb.rsize[i] + ($urandom_range(0, 9) == 0);
        end
      end
      rmpc_pkg::MODE_STAT, rmpc_pkg::MODE_UNUSED: begin
        a = rand64();
        len = rand64();
        pb = $urandom_range(0, 15);
      end
      default: begin
        if (region_sb.nlive > 0 && $urandom_range(0, 99) < 80) begin
          i = $urandom_range(0, region_sb.nlive - 1);
          a = region_sb.rbase[i] + rand64() % region_sb.rsize[i];
          len = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 64));
        end else if ($urandom_range(0, 1)) begin
          a = rand64();
          len = rand64() >> $urandom_range(0, 63);
        end
      end
    endcase
    send_req(md, a, len, pb, own, sel);
  endtask

  task automatic run_random(int n);
    int burst, gap;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n > 0; k++) begin
        send_random();
        n--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // limit registers are only written with nothing in flight
  task automatic set_limits(logic [63:0] rsz, logic [63:0] tot, logic [63:0] ents);
    logic [63:0] vals[3];
    vals = '{rsz, tot, ents};
    in_valid <= 1'b0;
    @(negedge clk);
    while (region_sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int k = 0; k < 3; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[1:0];
      cfg_wdata <= vals[k];
      @(negedge clk);
      region_sb.set_limit(k[1:0], vals[k]);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    win_base = (rand64() & ~64'hF_FFFF) >> $urandom_range(0, 40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: rejects, overlap, containment, permissions, release, overflow
    send_req(rmpc_pkg::MODE_STAT, 0, 0, 0, 0, rmpc_pkg::SEL_LIVE_COUNT);
    send_req(rmpc_pkg::MODE_MAP, 64'h1000, 64'h100, 4'hF, 1, 0);
    send_req(rmpc_pkg::MODE_MAP, 64'h1000, 64'h0, 4'h7, 1, 0);
    send_req(rmpc_pkg::MODE_MAP, ALL_ONES, 64'h2, 4'h7, 1, 0);
    send_req(rmpc_pkg::MODE_MAP, 64'h1000, 64'h100, 4'h7, 1, 0);
    send_req(rmpc_pkg::MODE_MAP, 64'h1080, 64'h10, 4'h3, 1, 0);
    send_req(rmpc_pkg::MODE_MAP, 64'h2000, 64'h100, 4'h1, 0, 0);
    send_req(rmpc_pkg::MODE_READ, 64'h1000, 64'h100, 0, 0, 0);
    send_req(rmpc_pkg::MODE_WRITE, 64'h2000, 64'h4, 0, 0, 0);
    send_req(rmpc_pkg::MODE_READ, 64'h10FF, 64'h2, 0, 0, 0);
    send_req(rmpc_pkg::MODE_READ, 64'h3000, 64'h0, 0, 0, 0);
    send_req(rmpc_pkg::MODE_READ, 64'h1000, 64'h0, 0, 0, 0);
    send_req(rmpc_pkg::MODE_LOADER, 64'h5000, 64'h0, 0, 0, 0);
    send_req(rmpc_pkg::MODE_LOADER, 64'h5000, 64'h4, 0, 0, 0);
    send_req(rmpc_pkg::MODE_LOADER, ALL_ONES, 64'h2, 0, 0, 0);
    send_req(rmpc_pkg::MODE_LOADER, 64'h2000, 64'h4, 0, 0, 0);
    send_req(rmpc_pkg::MODE_QUERY, 64'h1010, 64'h0, 0, 0, 0);
    send_req(rmpc_pkg::MODE_QUERY, 64'h1010, 64'h1, 0, 0, 0);
    send_req(rmpc_pkg::MODE_RELEASE, 64'h2000, 64'h100, 0, 0, 0);
    send_req(rmpc_pkg::MODE_RELEASE, 64'h1000, 64'hFF, 0, 0, 0);
    send_req(rmpc_pkg::MODE_RELEASE, 64'h1000, 64'h100, 0, 0, 0);
    send_req(rmpc_pkg::MODE_MAP, 64'h0, ALL_ONES, 4'h7, 0, 0);               // live total wraps
    send_req(rmpc_pkg::MODE_MAP, 64'h0, ~region_sb.live_bytes, 4'h7, 1, 0);  // cumulative wraps
    send_req(rmpc_pkg::MODE_STAT, 0, 0, 0, 0, 4'd12);
    send_req(rmpc_pkg::MODE_UNUSED, ALL_ONES, ALL_ONES, 4'hF, 1, 4'hF);

    run_random(450);
    set_limits(64'd4096, 64'd200000, 64'd12);
    run_random(300);
    set_limits(64'd1, ALL_ONES, 64'd64);
    run_random(200);
    set_limits(ALL_ONES, 64'd0, 64'd0);
    run_random(200);
    set_limits(ALL_ONES, ALL_ONES, 64'd64);
    run_random(600);

    in_valid <= 1'b0;
    while (region_sb.expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (region_sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", region_sb.expected_q.size());
      region_sb.errors++;
    end
    $display("%0d requests sent, %0d results checked over five limit settings",
             nsent, region_sb.nchecked);
    $display("%0d maps, %0d releases and %0d passing checks were seen",
             region_sb.nmapped, region_sb.nreleased, region_sb.naccess_ok);
    if (region_sb.errors == 0) begin
      $display("region_map_protection_checker_top verification clean");
    end else begin
      $display("region_map_protection_checker_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rmpc_pkg.sv
rtl/core/rmpc_ram.sv
rtl/core/region_map_protection_checker_top.sv
test/region_map_protection_checker_top_tb.sv
